@@ sv/cltok_pkg.sv @@
package cltok_pkg;

  localparam int MAX_TOKEN_LEN   = 1024;
  localparam int MAX_ARGUMENTS   = 80;
  localparam int ARG_STORE_BYTES = 1024;

  localparam int LEN_W   = 11;
  localparam int ARG_W   = 7;
  localparam int STORE_W = 11;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;

  localparam logic [7:0] SPACE_CODE = 8'h20;
  localparam logic [7:0] NL_CODE    = 8'h0A;
  localparam logic [7:0] QUOTE_CODE = 8'h22;
  localparam logic [7:0] SLASH_CODE = 8'h2F;
  localparam logic [7:0] NUL_CODE   = 8'h00;

  typedef enum logic [2:0] {
    M_BETWEEN = 3'd0,
    M_WORD    = 3'd1,
    M_QUOTE   = 3'd2,
    M_SLASH   = 3'd3,
    M_COMMENT = 3'd4,
    M_SKIP    = 3'd5
  } mode_t;

  // one token event from the scanner
  typedef struct packed {
    logic             has_byte;
    logic [7:0]       data;
    logic             done;
    logic             line;
    logic [LEN_W-1:0] len;
  } ev_t;

  // events caused by one input word
  typedef struct packed {
    ev_t  ev0;
    ev_t  ev1;
    logic two;
  } rec_t;

endpackage

@@ sv/cltok_front.sv @@
module cltok_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    char_in,
  output logic          push,
  output cltok_pkg::rec_t rec
);

  typedef struct packed {
    logic                        has;
    cltok_pkg::ev_t              ev;
    cltok_pkg::mode_t            mode;
    logic [cltok_pkg::LEN_W-1:0] len;
  } step_t;

  cltok_pkg::mode_t            mode, mode_next;
  logic [cltok_pkg::LEN_W-1:0] len, len_next;
  step_t                       s0, s1;
  logic                        full1;

  function automatic step_t line_step();
    step_t s;
    s = '0;
    s.has = 1'b1;
    s.ev.line = 1'b1;
    s.mode = cltok_pkg::M_BETWEEN;
    return s;
  endfunction

  // byte above space appended to a word
  function automatic step_t word_byte(logic [7:0] b, logic [cltok_pkg::LEN_W-1:0] l);
    step_t s;
    logic [cltok_pkg::LEN_W-1:0] inc;
    logic full;
    s = '0;
    inc = l + 1'b1;
    full = inc >= cltok_pkg::LEN_W'(cltok_pkg::MAX_TOKEN_LEN - 1);
    s.has = 1'b1;
    s.ev.has_byte = 1'b1;
    s.ev.data = b;
    s.ev.done = full;
    s.ev.len = inc;
    s.mode = full ? cltok_pkg::M_BETWEEN : cltok_pkg::M_WORD;
    s.len = full ? '0 : inc;
    return s;
  endfunction

  function automatic step_t in_word(logic [7:0] b, logic [cltok_pkg::LEN_W-1:0] l);
    step_t s;
    s = '0;
    if (b > cltok_pkg::SPACE_CODE) begin
      s = word_byte(b, l);
    end else begin
      s.has = 1'b1;
      s.ev.done = 1'b1;
      s.ev.line = (b == cltok_pkg::NUL_CODE) || (b == cltok_pkg::NL_CODE);
      s.ev.len = l;
      s.mode = cltok_pkg::M_BETWEEN;
    end
    return s;
  endfunction

  function automatic step_t between(logic [7:0] b);
    step_t s;
    s = '0;
    s.mode = cltok_pkg::M_BETWEEN;
    if ((b == cltok_pkg::NUL_CODE) || (b == cltok_pkg::NL_CODE)) begin
      s = line_step();
    end else if (b > cltok_pkg::SPACE_CODE) begin
      if (b == cltok_pkg::QUOTE_CODE) begin
        s.mode = cltok_pkg::M_QUOTE;
      end else if (b == cltok_pkg::SLASH_CODE) begin
        s.mode = cltok_pkg::M_SLASH;
      end else begin
        s = word_byte(b, '0);
      end
    end
    return s;
  endfunction

  always_comb begin
    s0 = '0;
    s1 = '0;
    s0.mode = mode;
    s0.len = len;
    full1 = 1 >= (cltok_pkg::MAX_TOKEN_LEN - 1);
    case (mode)
      cltok_pkg::M_WORD: begin
        s0 = in_word(char_in, len);
      end
      cltok_pkg::M_QUOTE: begin
        if (char_in == cltok_pkg::QUOTE_CODE) begin
          s0.has = 1'b1;
          s0.ev.done = 1'b1;
          s0.ev.len = len;
          s0.mode = cltok_pkg::M_BETWEEN;
          s0.len = '0;
        end else if (char_in == cltok_pkg::NUL_CODE) begin
          s0 = line_step();
          s0.ev.done = 1'b1;
          s0.ev.len = len;
        end else if (len < cltok_pkg::LEN_W'(cltok_pkg::MAX_TOKEN_LEN - 1)) begin
          s0.has = 1'b1;
          s0.ev.has_byte = 1'b1;
          s0.ev.data = char_in;
          s0.len = len + 1'b1;
        end
      end
      cltok_pkg::M_SLASH: begin
        if (char_in == cltok_pkg::SLASH_CODE) begin
          s0.mode = cltok_pkg::M_COMMENT;
        end else begin
          s0.has = 1'b1;
          s0.ev.has_byte = 1'b1;
          s0.ev.data = cltok_pkg::SLASH_CODE;
          s0.ev.done = full1;
          s0.ev.len = cltok_pkg::LEN_W'(1);
          if (full1) begin
            s0.mode = cltok_pkg::M_BETWEEN;
            s0.len = '0;
            s1 = between(char_in);
          end else begin
            s1 = in_word(char_in, cltok_pkg::LEN_W'(1));
          end
        end
      end
      cltok_pkg::M_COMMENT: begin
        if (char_in == cltok_pkg::NUL_CODE) begin
          s0 = line_step();
        end else if (char_in == cltok_pkg::NL_CODE) begin
          s0.mode = cltok_pkg::M_SKIP;
        end
      end
      cltok_pkg::M_SKIP: begin
        if ((char_in == cltok_pkg::NUL_CODE) || (char_in > cltok_pkg::SPACE_CODE)) begin
          s0 = between(char_in);
        end
      end
      default: begin
        s0 = between(char_in);
      end
    endcase

    mode_next = s1.has ? s1.mode : s0.mode;
    len_next  = s1.has ? s1.len : s0.len;
    if (s0.has && s1.has) begin
      rec.ev0 = s0.ev;
      rec.ev1 = s1.ev;
      rec.two = 1'b1;
    end else begin
      rec.ev0 = s1.has ? s1.ev : s0.ev;
      rec.ev1 = '0;
      rec.two = 1'b0;
    end
    push = accept && (s0.has || s1.has);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= cltok_pkg::M_BETWEEN;
      len  <= '0;
    end else if (accept) begin
      mode <= mode_next;
      len  <= len_next;
    end
  end

endmodule

@@ sv/cltok_queue.sv @@
module cltok_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cltok_pkg::rec_t wr_rec,
  input  logic            pop,
  output cltok_pkg::rec_t rd_rec,
  output logic            empty,
  output logic            full
);

  cltok_pkg::rec_t                 entries [cltok_pkg::QDEPTH];
  logic [cltok_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [cltok_pkg::QPTR_W:0]      count;

  assign empty  = (count == '0);
  assign full   = (count == (cltok_pkg::QPTR_W+1)'(cltok_pkg::QDEPTH));
  assign rd_rec = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sv/cltok_back.sv @@
module cltok_back (
  input  logic                        clk,
  input  logic                        rst,
  input  cltok_pkg::rec_t             rec,
  input  logic                        empty,
  output logic                        pop,
  input  logic                        result_ready,
  output logic                        result_valid,
  output logic [7:0]                  tok_byte,
  output logic                        byte_valid,
  output logic                        token_done,
  output logic                        token_kept,
  output logic [cltok_pkg::ARG_W-1:0] arg_number,
  output logic                        line_done,
  output logic                        store_overflow,
  output logic                        last_of_run
);

  logic                          sel, sel_next;
  logic [cltok_pkg::ARG_W-1:0]   arg_count, arg_count_next;
  logic [cltok_pkg::STORE_W-1:0] store_used, store_used_next;
  logic                          dropped, dropped_next;
  cltok_pkg::ev_t                ev;
  logic                          last, go, emit, kept, last_out;
  logic [cltok_pkg::STORE_W:0]   sum;

  always_comb begin
    ev   = sel ? rec.ev1 : rec.ev0;
    last = sel || !rec.two;
    go   = !empty && (!result_valid || result_ready);
    sum  = {1'b0, store_used} + (cltok_pkg::STORE_W+1)'(ev.len) + 1'b1;

    kept            = 1'b0;
    arg_count_next  = arg_count;
    store_used_next = store_used;
    dropped_next    = dropped;
    if (ev.done && !dropped &&
        (arg_count < cltok_pkg::ARG_W'(cltok_pkg::MAX_ARGUMENTS))) begin
      if (sum > (cltok_pkg::STORE_W+1)'(cltok_pkg::ARG_STORE_BYTES)) begin
        dropped_next = 1'b1;
      end else begin
        kept            = 1'b1;
        store_used_next = sum[cltok_pkg::STORE_W-1:0];
        arg_count_next  = arg_count + 1'b1;
      end
    end

    // a second event swallowed by a fresh overflow leaves this one last
    last_out = last || (!dropped && dropped_next && !rec.ev1.line);
    emit     = go && !(dropped && !ev.line);
    pop      = go && last;
    sel_next = go ? !last : sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel          <= 1'b0;
      arg_count    <= '0;
      store_used   <= '0;
      dropped      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      sel <= sel_next;
      if (go) begin
        if (ev.line) begin
          arg_count  <= '0;
          store_used <= '0;
          dropped    <= 1'b0;
        end else begin
          arg_count  <= arg_count_next;
          store_used <= store_used_next;
          dropped    <= dropped_next;
        end
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tok_byte       <= (ev.has_byte && !dropped) ? ev.data : 8'h00;
      byte_valid     <= ev.has_byte && !dropped;
      token_done     <= ev.done && !dropped;
      token_kept     <= kept;
      arg_number     <= arg_count;
      line_done      <= ev.line;
      store_overflow <= dropped_next;
      last_of_run    <= last_out;
    end
  end

endmodule

@@ sv/command_line_tokenizer_top.sv @@
// Command-line tokenizer: takes one text byte per word on char_in and streams
// token bytes with token and command boundaries, up to two result words per
// input byte (a held '/' that turns out not to open a comment is released
// with the byte after it). An input byte is taken every cycle while the
// four-entry event queue between the scanner and the argument bookkeeping
// has room; results leave from an output register at one per cycle while
// result_ready is high, so a byte that yields two results holds the back
// end for both. An accepted byte's events pass through the event queue and then the output register.
module command_line_tokenizer_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic [7:0]                  char_in,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [7:0]                  tok_byte,
  output logic                        byte_valid,
  output logic                        token_done,
  output logic                        token_kept,
  output logic [cltok_pkg::ARG_W-1:0] arg_number,
  output logic                        line_done,
  output logic                        store_overflow,
  output logic                        last_of_run
);

  logic            accept, push, pop, q_empty, q_full;
  cltok_pkg::rec_t wr_rec, rd_rec;

  assign item_ready = !q_full;
  assign accept     = item_valid && item_ready;

  cltok_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .char_in (char_in),
    .push    (push),
    .rec     (wr_rec)
  );

  cltok_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (wr_rec),
    .pop    (pop),
    .rd_rec (rd_rec),
    .empty  (q_empty),
    .full   (q_full)
  );

  cltok_back u_back (
    .clk            (clk),
    .rst            (rst),
    .rec            (rd_rec),
    .empty          (q_empty),
    .pop            (pop),
    .result_ready   (result_ready),
    .result_valid   (result_valid),
    .tok_byte       (tok_byte),
    .byte_valid     (byte_valid),
    .token_done     (token_done),
    .token_kept     (token_kept),
    .arg_number     (arg_number),
    .line_done      (line_done),
    .store_overflow (store_overflow),
    .last_of_run    (last_of_run)
  );

`ifndef SYNTHESIS
  a_kept_ends_token: assert property (@(posedge clk) disable iff (rst)
    result_valid && token_kept |-> token_done)
    else $error("kept flag without token end");

  a_overflow_no_byte: assert property (@(posedge clk) disable iff (rst)
    result_valid && store_overflow |-> !token_kept && (token_done || !byte_valid))
    else $error("token byte after store overflow");

  a_arg_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> arg_number <= cltok_pkg::ARG_W'(cltok_pkg::MAX_ARGUMENTS))
    else $error("argument number past limit");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("event queue overrun");
`endif

endmodule

@@ test/command_line_tokenizer_top_test.sv @@
`timescale 1ns / 100ps

module command_line_tokenizer_top_test;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam int LONG_WORD   = 0;
  localparam int LONG_QUOTE  = 1;
  localparam int MANY_ARGS   = 2;

  typedef struct packed {
    logic [7:0]                  tok_byte;
    logic                        byte_valid;
    logic                        token_done;
    logic                        token_kept;
    logic [cltok_pkg::ARG_W-1:0] arg_number;
    logic                        line_done;
    logic                        store_overflow;
    logic                        last_of_run;
  } tok_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  logic [7:0] char_in = 8'h00;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [7:0] tok_byte;
  logic byte_valid;
  logic token_done;
  logic token_kept;
  logic [cltok_pkg::ARG_W-1:0] arg_number;
  logic line_done;
  logic store_overflow;
  logic last_of_run;

  command_line_tokenizer_top DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .char_in(char_in),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .tok_byte(tok_byte),
    .byte_valid(byte_valid),
    .token_done(token_done),
    .token_kept(token_kept),
    .arg_number(arg_number),
    .line_done(line_done),
    .store_overflow(store_overflow),
    .last_of_run(last_of_run)
  );

  always #5 clk = ~clk;

  logic [7:0] text_bytes_pending [$];
  tok_result_t token_results_due [$];
  logic [7:0] opening_text [0:29] = '{
    "a", 8'hFF, 8'h01, "!", cltok_pkg::NL_CODE,
    cltok_pkg::QUOTE_CODE, cltok_pkg::SPACE_CODE, cltok_pkg::NL_CODE,
    cltok_pkg::QUOTE_CODE, cltok_pkg::NUL_CODE,
    cltok_pkg::QUOTE_CODE, "q", cltok_pkg::NUL_CODE,
    cltok_pkg::SLASH_CODE, cltok_pkg::SLASH_CODE, cltok_pkg::NL_CODE,
    cltok_pkg::SPACE_CODE, cltok_pkg::NL_CODE, "z", cltok_pkg::NL_CODE,
    cltok_pkg::SLASH_CODE, cltok_pkg::NL_CODE,
    cltok_pkg::SLASH_CODE, cltok_pkg::SPACE_CODE, cltok_pkg::SLASH_CODE,
    cltok_pkg::QUOTE_CODE, cltok_pkg::NUL_CODE,
    cltok_pkg::SLASH_CODE, cltok_pkg::SLASH_CODE, cltok_pkg::NUL_CODE
  };

  // tokenizer shadow state
  cltok_pkg::mode_t scan_state = cltok_pkg::M_BETWEEN;
  int tok_len = 0;
  int args_kept = 0;
  int store_used = 0;
  bit line_dropped = 1'b0;
  tok_result_t step_res [0:1];
  int step_n;

  int fails = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  bit in_taken = 1'b0;
  int send_gap = 0;
  int send_calm = 0;
  int ready_stall = 0;
  int recv_calm = 0;
  int hold_left = 0;
  bit pressure_done = 1'b0;
  tok_result_t want;

  function automatic bit claim_arg_slot();
    if (args_kept >= cltok_pkg::MAX_ARGUMENTS) return 1'b0;
    if (store_used + tok_len + 1 > cltok_pkg::ARG_STORE_BYTES) begin
      line_dropped = 1'b1;
      return 1'b0;
    end
    store_used += tok_len + 1;
    args_kept++;
    return 1'b1;
  endfunction

  function automatic void note_result(bit has_b, logic [7:0] b, bit done, bit line);
    bit was;
    int argn;
    bit kept;
    tok_result_t r;
    was = line_dropped;
    argn = args_kept;
    kept = 1'b0;
    if (done && !was) kept = claim_arg_slot();
    if (done) tok_len = 0;
    if (was && !line) return;
    if (step_n >= 2) return;
    r.tok_byte = (has_b && !was) ? b : 8'h00;
    r.byte_valid = has_b && !was;
    r.token_done = done && !was;
    r.token_kept = kept;
    r.arg_number = argn[cltok_pkg::ARG_W-1:0];
    r.line_done = line;
    r.store_overflow = line_dropped;
    r.last_of_run = 1'b0;
    step_res[step_n] = r;
    step_n++;
    if (line) begin
      scan_state = cltok_pkg::M_BETWEEN;
      tok_len = 0;
      args_kept = 0;
      store_used = 0;
      line_dropped = 1'b0;
    end
  endfunction

  function automatic void take_word_byte(logic [7:0] b);
    bit full;
    tok_len++;
    full = tok_len >= cltok_pkg::MAX_TOKEN_LEN - 1;
    if (full) scan_state = cltok_pkg::M_BETWEEN;
    else scan_state = cltok_pkg::M_WORD;
    note_result(1'b1, b, full, 1'b0);
  endfunction

  function automatic void open_token(logic [7:0] b);
    tok_len = 0;
    if (b == cltok_pkg::QUOTE_CODE) scan_state = cltok_pkg::M_QUOTE;
    else if (b == cltok_pkg::SLASH_CODE) scan_state = cltok_pkg::M_SLASH;
    else take_word_byte(b);
  endfunction

  function automatic void scan_gap(logic [7:0] b);
    if (b == cltok_pkg::NUL_CODE || b == cltok_pkg::NL_CODE)
      note_result(1'b0, 8'h00, 1'b0, 1'b1);
    else if (b > cltok_pkg::SPACE_CODE) open_token(b);
  endfunction

  function automatic void scan_word(logic [7:0] b);
    if (b > cltok_pkg::SPACE_CODE) begin
      take_word_byte(b);
    end else begin
      scan_state = cltok_pkg::M_BETWEEN;
      note_result(1'b0, 8'h00, 1'b1, b == cltok_pkg::NUL_CODE || b == cltok_pkg::NL_CODE);
    end
  endfunction

  function automatic void tokenize_byte(logic [7:0] b);
    bit full;
    step_n = 0;
    case (scan_state)
      cltok_pkg::M_WORD: scan_word(b);
      cltok_pkg::M_QUOTE: begin
        if (b == cltok_pkg::QUOTE_CODE) begin
          scan_state = cltok_pkg::M_BETWEEN;
          note_result(1'b0, 8'h00, 1'b1, 1'b0);
        end else if (b == cltok_pkg::NUL_CODE) begin
          scan_state = cltok_pkg::M_BETWEEN;
          note_result(1'b0, 8'h00, 1'b1, 1'b1);
        end else if (tok_len < cltok_pkg::MAX_TOKEN_LEN - 1) begin
          tok_len++;
          note_result(1'b1, b, 1'b0, 1'b0);
        end
      end
      cltok_pkg::M_SLASH: begin
        if (b == cltok_pkg::SLASH_CODE) begin
          scan_state = cltok_pkg::M_COMMENT;
        end else begin
          // held slash was a plain word start
          tok_len = 1;
          full = tok_len >= cltok_pkg::MAX_TOKEN_LEN - 1;
          if (full) scan_state = cltok_pkg::M_BETWEEN;
          else scan_state = cltok_pkg::M_WORD;
          note_result(1'b1, cltok_pkg::SLASH_CODE, full, 1'b0);
          if (full) scan_gap(b);
          else scan_word(b);
        end
      end
      cltok_pkg::M_COMMENT: begin
        if (b == cltok_pkg::NUL_CODE) note_result(1'b0, 8'h00, 1'b0, 1'b1);
        else if (b == cltok_pkg::NL_CODE) scan_state = cltok_pkg::M_SKIP;
      end
      cltok_pkg::M_SKIP: begin
        if (b == cltok_pkg::NUL_CODE) note_result(1'b0, 8'h00, 1'b0, 1'b1);
        else if (b > cltok_pkg::SPACE_CODE) open_token(b);
      end
      default: begin
        scan_state = cltok_pkg::M_BETWEEN;
        scan_gap(b);
      end
    endcase
    if (step_n > 0) step_res[step_n-1].last_of_run = 1'b1;
    for (int i = 0; i < step_n; i++) token_results_due.push_back(step_res[i]);
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] word_char();
    return 8'($urandom_range(33, 255));
  endfunction

  function automatic logic [7:0] sep_char();
    logic [7:0] c;
    c = 8'($urandom_range(1, 32));
    if (c == cltok_pkg::NL_CODE || $urandom_range(0, 1) == 0) c = cltok_pkg::SPACE_CODE;
    return c;
  endfunction

  function automatic logic [7:0] quoted_char();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    if (c == cltok_pkg::QUOTE_CODE) c = cltok_pkg::SPACE_CODE;
    return c;
  endfunction

  task automatic put_word(int len);
    for (int i = 0; i < len; i++) text_bytes_pending.push_back(word_char());
  endtask

  task automatic put_tokens(int n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      repeat ($urandom_range(0, 3)) text_bytes_pending.push_back(sep_char());
      case ($urandom_range(0, 9))
        5, 6: begin
          text_bytes_pending.push_back(cltok_pkg::QUOTE_CODE);
          repeat ($urandom_range(0, 12)) text_bytes_pending.push_back(quoted_char());
          if ($urandom_range(0, 9) != 0) text_bytes_pending.push_back(cltok_pkg::QUOTE_CODE);
        end
        7: begin
          text_bytes_pending.push_back(cltok_pkg::SLASH_CODE);
          put_word($urandom_range(0, 6));
        end
        8: begin
          text_bytes_pending.push_back(cltok_pkg::SLASH_CODE);
          text_bytes_pending.push_back(cltok_pkg::SLASH_CODE);
          repeat ($urandom_range(0, 10)) begin
            c = 8'($urandom_range(1, 255));
            if (c == cltok_pkg::NL_CODE) c = cltok_pkg::SPACE_CODE;
            text_bytes_pending.push_back(c);
          end
          if ($urandom_range(0, 6) != 0) text_bytes_pending.push_back(cltok_pkg::NL_CODE);
        end
        9: text_bytes_pending.push_back(cltok_pkg::SLASH_CODE);
        default: put_word($urandom_range(1, 12));
      endcase
    end
  endtask

  task automatic end_line();
    if ($urandom_range(0, 4) == 0) text_bytes_pending.push_back(cltok_pkg::NUL_CODE);
    else text_bytes_pending.push_back(cltok_pkg::NL_CODE);
  endtask

  task automatic put_long(int kind);
    case (kind)
      LONG_WORD: begin
        text_bytes_pending.push_back("A");
        put_word(cltok_pkg::MAX_TOKEN_LEN - 2 + $urandom_range(1, 30));
      end
      LONG_QUOTE: begin
        text_bytes_pending.push_back(cltok_pkg::QUOTE_CODE);
        repeat (cltok_pkg::MAX_TOKEN_LEN - 1 + $urandom_range(1, 30))
          text_bytes_pending.push_back(quoted_char());
        text_bytes_pending.push_back(cltok_pkg::QUOTE_CODE);
      end
      default: begin
        repeat (cltok_pkg::MAX_ARGUMENTS + $urandom_range(1, 8)) begin
          text_bytes_pending.push_back(cltok_pkg::SPACE_CODE);
          put_word($urandom_range(1, 2));
        end
      end
    endcase
    put_tokens($urandom_range(1, 5));
    end_line();
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_taken || !item_valid) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        item_valid <= 1'b0;
      end else if (text_bytes_pending.size() > 0) begin
        char_in <= text_bytes_pending.pop_front();
        item_valid <= 1'b1;
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else if ($urandom_range(0, 149) == 0) begin
          send_calm = $urandom_range(100, 300);
          send_gap = 0;
        end else begin
          send_gap = ($urandom_range(0, 2) == 0) ? idle_len() : 0;
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else if (!pressure_done && results_seen >= 200) begin
      // long hold-off so the input side backs up
      pressure_done = 1'b1;
      hold_left = 400;
      result_ready <= 1'b0;
    end else if (ready_stall > 0) begin
      ready_stall--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
      if (recv_calm > 0) recv_calm--;
      else if ($urandom_range(0, 149) == 0) recv_calm = $urandom_range(100, 300);
      else if ($urandom_range(0, 3) == 0) ready_stall = idle_len();
    end
  end

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fails++;
    end
  endtask

  // monitor, tokenizer prediction, watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) begin
        results_seen++;
        if (token_results_due.size() == 0) begin
          $error("result word with nothing expected");
          fails++;
        end else begin
          want = token_results_due.pop_front();
          check_field("tok_byte", want.tok_byte, tok_byte);
          check_field("byte_valid", want.byte_valid, byte_valid);
          check_field("token_done", want.token_done, token_done);
          check_field("token_kept", want.token_kept, token_kept);
          check_field("arg_number", want.arg_number, arg_number);
          check_field("line_done", want.line_done, line_done);
          check_field("store_overflow", want.store_overflow, store_overflow);
          check_field("last_of_run", want.last_of_run, last_of_run);
        end
      end
      if (item_valid && item_ready) begin
        tokenize_byte(char_in);
        in_taken = 1'b1;
      end
      if ((result_valid && result_ready) || (item_valid && item_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    int cmd;
    foreach (opening_text[i]) text_bytes_pending.push_back(opening_text[i]);
    cmd = 0;
    while (text_bytes_pending.size() < 1800 || cmd < 12) begin
      cmd++;
      if (cmd == 3) begin
        put_long(LONG_WORD);
      end else if (cmd == 12) begin
        put_long(LONG_QUOTE);
      end else if (cmd == 7 || $urandom_range(0, 59) == 0) begin
        put_long(MANY_ARGS);
      end else if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 20))
          text_bytes_pending.push_back(8'($urandom_range(0, 255)));
      end else begin
        put_tokens($urandom_range(0, 6));
        end_line();
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (text_bytes_pending.size() > 0 || item_valid) @(posedge clk);
    while (token_results_due.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
